FILE: hdl/sahc_pkg.sv
`default_nettype none
package sahc_pkg;

  typedef enum logic [1:0] {
    OP_GET        = 2'd0,
    OP_PUT        = 2'd1,
    OP_PUT_OR_GET = 2'd2,
    OP_DELETE     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_HIT       = 4'd0,
    ST_MISS      = 4'd1,
    ST_REPLACED  = 4'd2,
    ST_INSERTED  = 4'd3,
    ST_EVICTED   = 4'd4,
    ST_EXISTS    = 4'd5,
    ST_FULL      = 4'd6,
    ST_DELETED   = 4'd7,
    ST_NOT_FOUND = 4'd8
  } status_e;

  localparam int unsigned CfgW    = 11;
  localparam int unsigned HashW   = 32;
  localparam int unsigned KeyLenW = 4;
  localparam int unsigned InHandW = 16;
  localparam int unsigned StatW   = 4;

endpackage
`default_nettype wire

FILE: hdl/set_assoc_hash_cache_unit.sv
// Set-associative hash cache with round-robin replacement.
// s_axis: one request beat; tdata = opcode, hash, key, key_len, new_handle,
// allow_replace packed from bit 0. m_axis: one result beat per request;
// tdata = status, result_handle. cfg: write of bucket_count (0 acts as 1,
// larger than MAX_BUCKETS acts as MAX_BUCKETS).
// A request passes through 32 bit-serial steps of hash modulo bucket_count,
// a step to latch the bucket, a bucket memory read and a compare-and-write
// step before its result beat. The unit then returns to idle and takes no
// new request until it is through with the last one.
// The bucket lives in a wide memory, one row per bucket holding all ways.
// After reset a clearing pass over all MAX_BUCKETS rows clears valid bits and
// round-robin pointers; no request is taken meanwhile. The result waits
// in an output register while the receiver stalls; each stalled cycle
// delays the next request, which is taken once that register is free.
`default_nettype none
module set_assoc_hash_cache_unit #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned WAYS        = 8,
  parameter int unsigned KEY_BYTES   = 8,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // opcode[1:0] hash[33:2] key[97:34] key_len[101:98] new_handle[117:102]
  // allow_replace[118]
  input  wire logic [119:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // status[3:0] result_handle[19:4]
  output logic [23:0]        m_axis_tdata,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [10:0]   cfg_data
);
  localparam int unsigned BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned KW  = 8 * KEY_BYTES;
  localparam int unsigned HB  = HANDLE_BITS;

  typedef struct packed {
    logic [31:0]   hash;
    logic [KW-1:0] key;
    logic [3:0]    len;
    logic [HB-1:0] hnd;
  } entry_t;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_MOD  = 6'b000100,
    S_RD   = 6'b001000,
    S_CMP  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [10:0] nb_q;
  logic [BW:0] div;

  entry_t ent_mem [MAX_BUCKETS][WAYS];
  logic [WAYS-1:0] vld_mem [MAX_BUCKETS];
  logic [WW-1:0]   vp_mem  [MAX_BUCKETS];

  entry_t          ent_rd [WAYS];
  logic [WAYS-1:0] vld_rd;
  logic [WW-1:0]   vp_rd;

  logic [1:0]    op_q;
  logic [31:0]   hash_q;
  logic [KW-1:0] key_q;
  logic [3:0]    len_q;
  logic [HB-1:0] nh_q;
  logic          repl_q;
  logic [BW-1:0] bkt_q;
  logic [BW-1:0] clr_q;

  logic          mod_done;
  logic [BW-1:0] mod_rem;

  logic [3:0]    st_q;
  logic [15:0]   rh_q;
  logic          ov_q;

  logic          acc;
  logic [3:0]    in_len;
  logic [3:0]    sat_len;
  logic [63:0]   kmask;

  // clamp bucket count
  always_comb begin
    if (nb_q == 11'd0) begin
      div = (BW+1)'(1);
    end else if ({21'd0, nb_q} > 32'(MAX_BUCKETS)) begin
      div = (BW+1)'(MAX_BUCKETS);
    end else begin
      div = (BW+1)'(nb_q);
    end
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q <= 11'(MAX_BUCKETS);
    end else if (cfg_valid) begin
      nb_q <= cfg_data;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign in_len = s_axis_tdata[101:98];
  assign sat_len = (32'(in_len) > KEY_BYTES) ? 4'(KEY_BYTES) : in_len;

  always_comb begin
    kmask = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < 32'(sat_len)) kmask[i*8 +: 8] = 8'hff;
    end
  end

  sahc_mod #(.BW(BW)) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(acc),
    .hash_i (s_axis_tdata[33:2]),
    .div_i  (div),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q   <= s_axis_tdata[1:0];
      hash_q <= s_axis_tdata[33:2];
      key_q  <= KW'(s_axis_tdata[97:34] & kmask);
      len_q  <= sat_len;
      nh_q   <= HB'(s_axis_tdata[117:102]);
      repl_q <= s_axis_tdata[118];
    end
    if (mod_done) bkt_q <= mod_rem;
  end

  // compare
  logic [WAYS-1:0] hit;
  logic            any_hit, any_emp;
  logic [WW-1:0]   hit_w, emp_w;
  always_comb begin
    hit = '0;
    any_hit = 1'b0;
    any_emp = 1'b0;
    hit_w = '0;
    emp_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = vld_rd[w] && ent_rd[w].hash == hash_q && ent_rd[w].len == len_q &&
               ent_rd[w].key == key_q;
      if (!vld_rd[w]) begin
        any_emp = 1'b1;
        emp_w = WW'(w);
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        any_hit = 1'b1;
        hit_w = WW'(w);
      end
    end
  end

  logic          wr_ent, wr_vld, wr_vp;
  logic [WW-1:0] wr_w;
  entry_t        wr_data;
  logic [WAYS-1:0] vld_new;
  logic [WW-1:0] vp_new;
  logic [3:0]    st_d;
  logic [HB-1:0] rh_d;

  always_comb begin
    wr_ent  = 1'b0;
    wr_vld  = 1'b0;
    wr_vp   = 1'b0;
    wr_w    = hit_w;
    wr_data = '{hash: hash_q, key: key_q, len: len_q, hnd: nh_q};
    vld_new = vld_rd;
    vp_new  = (32'(vp_rd) == WAYS - 1) ? '0 : WW'(vp_rd + 1'b1);
    rh_d    = '0;
    st_d    = sahc_pkg::ST_FULL;
    case (sahc_pkg::op_e'(op_q))
      sahc_pkg::OP_GET: begin
        st_d = any_hit ? sahc_pkg::ST_HIT : sahc_pkg::ST_MISS;
        if (any_hit) rh_d = ent_rd[hit_w].hnd;
      end
      sahc_pkg::OP_DELETE: begin
        st_d = any_hit ? sahc_pkg::ST_DELETED : sahc_pkg::ST_NOT_FOUND;
        if (any_hit) begin
          rh_d = ent_rd[hit_w].hnd;
          vld_new[hit_w] = 1'b0;
          wr_vld = 1'b1;
        end
      end
      default: begin
        if (any_hit) begin
          if (sahc_pkg::op_e'(op_q) == sahc_pkg::OP_PUT) begin
            st_d = sahc_pkg::ST_REPLACED;
            rh_d = nh_q;
            wr_data = ent_rd[hit_w];
            wr_data.hnd = nh_q;
            wr_ent = 1'b1;
          end else begin
            st_d = sahc_pkg::ST_EXISTS;
            rh_d = ent_rd[hit_w].hnd;
          end
        end else if (any_emp) begin
          st_d = sahc_pkg::ST_INSERTED;
          rh_d = nh_q;
          wr_w = emp_w;
          wr_ent = 1'b1;
          vld_new[emp_w] = 1'b1;
          wr_vld = 1'b1;
        end else if (repl_q) begin
          st_d = sahc_pkg::ST_EVICTED;
          rh_d = ent_rd[vp_rd].hnd;
          wr_w = vp_rd;
          wr_ent = 1'b1;
          wr_vp = 1'b1;
        end
      end
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      for (int w = 0; w < WAYS; w++) ent_rd[w] <= ent_mem[bkt_q][w];
      vld_rd <= vld_mem[bkt_q];
      vp_rd  <= vp_mem[bkt_q];
    end
    if (state_q == S_CLR) begin
      vld_mem[clr_q] <= '0;
      vp_mem[clr_q]  <= '0;
    end else if (state_q == S_CMP) begin
      if (wr_ent) ent_mem[bkt_q][wr_w] <= wr_data;
      if (wr_vld) vld_mem[bkt_q] <= vld_new;
      if (wr_vp)  vp_mem[bkt_q] <= vp_new;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (32'(clr_q) == MAX_BUCKETS - 1) state_d = S_IDLE;
      S_IDLE: if (acc) state_d = S_MOD;
      S_MOD:  if (mod_done) state_d = S_RD;
      S_RD:   state_d = S_CMP;
      S_CMP:  state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= BW'(clr_q + 1'b1);
      if (state_q == S_CMP) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CMP) begin
      st_q <= st_d;
      rh_q <= 16'(rh_d);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, rh_q, st_q};

  // state stays one-hot; no new request while a result is held
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !s_axis_tready) else $error("accept while result pending");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == S_MOD) else $error("modulo done out of phase");
endmodule
`default_nettype wire

FILE: hdl/sahc_mod.sv
`default_nettype none
// Iterative hash mod bucket count, one quotient bit per cycle.
module sahc_mod #(
  parameter int unsigned BW = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [31:0]            hash_i,
  input  wire logic [BW:0]            div_i,
  output logic                        done_o,
  output logic [BW-1:0]               rem_o
);
  logic [31:0] num_q, num_d;
  logic [BW:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [BW+1:0] trial;

  assign trial = {rem_q, num_q[31]};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = hash_i;
      rem_d  = '0;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (trial >= {1'b0, div_i}) begin
        rem_d = (BW+1)'(trial - {1'b0, div_i});
      end else begin
        rem_d = trial[BW:0];
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[BW-1:0];
endmodule
`default_nettype wire
